// ----- sv/rrwl_pkg.sv -----
// Package for the recursive reader-writer lock table.
// Operation and status codes, per-entry count record and parameter defaults.
// No dependencies.
package rrwl_pkg;

	localparam int NUM_LOCKS_DEF  = 64;
	localparam int OWNER_BITS_DEF = 16;

	localparam int FUNC_W  = 3;
	localparam int INDEX_W = 6;
	localparam int OWNER_W = 16;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ACQ_EX  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ACQ_SH  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
	localparam logic [STAT_W-1:0] ST_BUSY_NOWAIT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BUSY_WAIT    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_HELD     = 3'd3;
	localparam logic [STAT_W-1:0] ST_DELETED_HELD = 3'd4;

	// counters and mode of one lock entry (owner slot is kept apart, its width is a parameter)
	typedef struct packed {
		logic [CNT_W-1:0] rec;
		logic [CNT_W-1:0] hold;
		logic [CNT_W-1:0] tally;
		logic             excl;
	} cnt_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ----- sv/rrwl_if.sv -----
// Request and response channel interfaces of the lock table.
// Depends on rrwl_pkg for field widths.
interface rrwl_req_if import rrwl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [INDEX_W-1:0] lock_index;
	logic [OWNER_W-1:0] owner_id;
	logic               may_wait;

	modport source (output valid, func, lock_index, owner_id, may_wait, input ready);
	modport sink   (input valid, func, lock_index, owner_id, may_wait, output ready);
endinterface

interface rrwl_rsp_if import rrwl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              granted;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  holders_left;
	logic [CNT_W-1:0]  recursion_left;

	modport source (output valid, granted, status, holders_left, recursion_left, input ready);
	modport sink   (input valid, granted, status, holders_left, recursion_left, output ready);
endinterface

// ----- sv/recursive_rw_lock_table.sv -----
// Recursive reader-writer lock table, top level.
// Depends on rrwl_pkg and the channel interfaces in rrwl_if.sv.
//
//   channel | dir | payload                                          | handshake
//   --------+-----+--------------------------------------------------+-------------
//   req     | in  | func, lock_index, owner_id, may_wait             | valid/ready
//   rsp     | out | granted, status, holders_left, recursion_left    | valid/ready
//
// One request per cycle sustained while rsp is not stalled. A request passes the
// read stage (table read registered) and then the response register.
// Back-to-back requests to the same lock are served by a one-entry bypass of the
// last written entry, so there is no bubble.
// Reset clears all entries at once through per-entry valid flops; no sweep.
// A stalled response holds the read stage; req.ready drops only then.
module recursive_rw_lock_table
	import rrwl_pkg::*;
#(
	parameter int NUM_LOCKS  = NUM_LOCKS_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rrwl_req_if.sink   req,
	rrwl_rsp_if.source rsp
);

	// only 64 entries can be named by the index field
	localparam int DEPTH = (NUM_LOCKS < (1 << INDEX_W)) ? NUM_LOCKS : (1 << INDEX_W);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WB    = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;

	// table storage: owner slots and counters, read registered
	logic [OWNER_BITS-1:0] mem_own [DEPTH];
	cnt_t                  mem_cnt [DEPTH];
	logic [DEPTH-1:0]      ent_vld_q;

	// read stage
	logic                  vld_s1;
	logic [FUNC_W-1:0]     func_s1;
	logic [AW-1:0]         addr_s1;
	logic                  inrange_s1;
	logic [OWNER_BITS-1:0] who_s1;
	logic                  wait_s1;
	logic                  hit_s1;
	logic                  rd_vld_s1;
	logic [OWNER_BITS-1:0] rd_own_s1;
	cnt_t                  rd_cnt_s1;

	// bypass copy of the last written entry
	logic [OWNER_BITS-1:0] byp_own_q;
	cnt_t                  byp_cnt_q;

	// response register
	logic                  out_vld_q;
	logic                  granted_q;
	logic [STAT_W-1:0]     status_q;
	logic [CNT_W-1:0]      hold_q;
	logic [CNT_W-1:0]      rec_q;

	logic                  advance;
	logic                  accept;
	logic                  wr_en;
	logic [AW-1:0]         req_addr;
	logic                  req_inrange;
	logic [OWNER_BITS-1:0] req_who;

	logic [OWNER_BITS-1:0] cur_own, nxt_own;
	cnt_t                  cur_cnt, nxt_cnt;
	logic                  nxt_granted;
	logic [STAT_W-1:0]     nxt_status;
	logic                  is_excl;

	assign advance     = !out_vld_q || rsp.ready;
	assign req.ready   = !vld_s1 || advance;
	assign accept      = req.valid && req.ready;
	assign wr_en       = vld_s1 && advance && inrange_s1;
	assign req_addr    = req.lock_index[AW-1:0];
	assign req_inrange = 32'(req.lock_index) < NUM_LOCKS;
	assign req_who     = OWNER_BITS'(req.owner_id[WB-1:0]);

	// entry as seen by the request in the read stage
	always_comb begin
		if (hit_s1) begin
			cur_own = byp_own_q;
			cur_cnt = byp_cnt_q;
		end else if (rd_vld_s1) begin
			cur_own = rd_own_s1;
			cur_cnt = rd_cnt_s1;
		end else begin
			cur_own = '0;
			cur_cnt = '0;
		end
	end

	assign is_excl = (func_s1 == FN_ACQ_EX);

	// one read-modify-write of the entry
	always_comb begin
		nxt_own     = cur_own;
		nxt_cnt     = cur_cnt;
		nxt_granted = 1'b0;
		nxt_status  = ST_OK;
		unique case (func_s1)
			FN_CLEAR: begin
				nxt_own = '0;
				nxt_cnt = '0;
			end
			FN_ACQ_EX, FN_ACQ_SH: begin
				if (cur_cnt.hold == '0) begin
					// first holder takes the slot
					nxt_own       = who_s1;
					nxt_cnt.rec   = CNT_W'(1);
					nxt_cnt.hold  = CNT_W'(1);
					nxt_cnt.tally = CNT_W'(1);
					nxt_cnt.excl  = is_excl;
					nxt_granted   = 1'b1;
				end else if (cur_own == who_s1 || (!is_excl && !cur_cnt.excl)) begin
					// recursion by the owner, or a reader joining readers
					if (cur_own != who_s1) begin
						nxt_cnt.hold  = sat_inc(cur_cnt.hold);
						nxt_cnt.tally = sat_inc(cur_cnt.tally);
					end
					nxt_own     = who_s1;
					nxt_cnt.rec = sat_inc(cur_cnt.rec);
					nxt_granted = 1'b1;
				end else begin
					nxt_status = wait_s1 ? ST_BUSY_WAIT : ST_BUSY_NOWAIT;
				end
			end
			FN_RELEASE: begin
				if (cur_cnt.rec == '0 || cur_cnt.hold == '0) begin
					nxt_status = ST_NOT_HELD;
				end else if (cur_cnt.rec > CNT_W'(1)) begin
					nxt_cnt.rec = cur_cnt.rec - CNT_W'(1);
				end else begin
					// last recursive release drops one holder
					nxt_own      = '0;
					nxt_cnt.rec  = '0;
					nxt_cnt.hold = cur_cnt.hold - CNT_W'(1);
					nxt_cnt.excl = 1'b0;
					if (cur_cnt.hold == CNT_W'(1)) begin
						nxt_cnt.tally = '0;
					end
				end
			end
			FN_DELETE: begin
				if (cur_cnt.hold != '0) begin
					nxt_status = ST_DELETED_HELD;
				end
				nxt_own = '0;
				nxt_cnt = '0;
			end
			default: begin
				// undefined operation: report current counts, change nothing
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_own[addr_s1] <= nxt_own;
			mem_cnt[addr_s1] <= nxt_cnt;
		end
		if (accept) begin
			rd_own_s1 <= mem_own[req_addr];
			rd_cnt_s1 <= mem_cnt[req_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[addr_s1] <= 1'b1;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	// read stage payload; hit marks a read that raced the write of the same entry
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= req.func;
			addr_s1    <= req_addr;
			inrange_s1 <= req_inrange;
			who_s1     <= req_who;
			wait_s1    <= req.may_wait;
			hit_s1     <= wr_en && (req_addr == addr_s1);
			rd_vld_s1  <= ent_vld_q[req_addr];
		end
		if (wr_en) begin
			byp_own_q <= nxt_own;
			byp_cnt_q <= nxt_cnt;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && advance) begin
			if (inrange_s1) begin
				granted_q <= nxt_granted;
				status_q  <= nxt_status;
				hold_q    <= nxt_cnt.hold;
				rec_q     <= nxt_cnt.rec;
			end else begin
				granted_q <= 1'b0;
				status_q  <= ST_NOT_HELD;
				hold_q    <= '0;
				rec_q     <= '0;
			end
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.granted        = granted_q;
	assign rsp.status         = status_q;
	assign rsp.holders_left   = hold_q;
	assign rsp.recursion_left = rec_q;

endmodule
